// ===== rtl/core/krfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// krfc_pkg
// Shared types, constants and the byte-wise CRC-16 update for the key
// report frame checker.
// ----------------------------------------------------------------------------
package krfc_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CrcW  = 16;
    localparam int unsigned MaskW = 24;
    localparam int unsigned PosW  = 3;

    typedef logic [ByteW-1:0] t_byte;
    typedef logic [CrcW-1:0]  t_crc;
    typedef logic [MaskW-1:0] t_mask;
    typedef logic [PosW-1:0]  t_pos;

    localparam t_crc  CrcPoly   = 16'h1021;
    localparam t_crc  CrcTopBit = 16'h8000;
    localparam t_byte FixByte0  = 8'd6;
    localparam t_byte FixByte1  = 8'd3;

    // frame byte positions
    localparam t_pos PosHdr0  = 3'd0;
    localparam t_pos PosHdr1  = 3'd1;
    localparam t_pos PosMask0 = 3'd2;
    localparam t_pos PosMask1 = 3'd3;
    localparam t_pos PosMask2 = 3'd4;
    localparam t_pos PosCrcLo = 3'd5;
    localparam t_pos PosCrcHi = 3'd6;
    localparam t_pos PosIdle  = 3'd7;

    // MSB-first CRC-16, one byte
    function automatic t_crc crc_feed(input t_crc crc, input t_byte data);
        t_crc c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < ByteW; k++) begin
            if ((c & CrcTopBit) != '0) begin
                c = (c << 1) ^ CrcPoly;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/key_report_frame_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_report_frame_checker
// A byte accepted into the input register is processed when it moves on;
// the frame result is written to the result register as the last byte is
// processed (two-stage path: input register, then result register).
// Throughput: one byte per cycle unless the master side stalls; combinational CRC.
// Reset (synchronous, active low): both stages empty, frame position idle,
// CRC, mask and stored CRC low byte cleared.
// ----------------------------------------------------------------------------
module key_report_frame_checker (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // slave side
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  krfc_pkg::t_byte   s_axis_tdata,   // [7:0] rx_byte
    input  wire                     s_axis_tuser,   // [0] frame_start
    // master side
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output krfc_pkg::t_mask         m_axis_tdata,   // [23:0] key_mask
    output logic                    m_axis_tuser    // [0] crc_ok
);
    import krfc_pkg::*;

    logic  r_in_valid, n_in_valid;
    t_byte r_in_byte;
    logic  r_in_start;

    t_pos  r_pos,    n_pos;
    t_crc  r_crc,    n_crc;
    t_mask r_mask,   n_mask;
    t_byte r_crc_lo, n_crc_lo;

    logic  r_out_valid, n_out_valid;
    t_mask r_out_mask,  n_out_mask;
    logic  r_out_ok,    n_out_ok;

    logic  w_adv;
    logic  w_proc;
    logic  w_emit;
    logic  w_ok;
    t_pos  w_pos;
    t_crc  w_rx_crc;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_proc        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_pos         = r_in_start ? PosHdr0 : r_pos;
    assign w_rx_crc      = {r_in_byte, r_crc_lo};
    assign w_ok          = (w_rx_crc == r_crc);

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_mask   = r_mask;
        n_crc_lo = r_crc_lo;
        w_emit   = 1'b0;
        if (w_proc) begin
            unique case (w_pos)
                PosHdr0: begin
                    n_crc  = crc_feed('0, FixByte0);
                    n_mask = '0;
                    n_pos  = PosHdr1;
                end
                PosHdr1: begin
                    n_crc = crc_feed(r_crc, FixByte1);
                    n_pos = PosMask0;
                end
                PosMask0: begin
                    n_crc  = crc_feed(r_crc, r_in_byte);
                    n_mask = {16'h0000, r_in_byte};
                    n_pos  = PosMask1;
                end
                PosMask1: begin
                    n_crc  = crc_feed(r_crc, r_in_byte);
                    n_mask = r_mask | {8'h00, r_in_byte, 8'h00};
                    n_pos  = PosMask2;
                end
                PosMask2: begin
                    n_crc  = crc_feed(r_crc, r_in_byte);
                    n_mask = r_mask | {r_in_byte, 16'h0000};
                    n_pos  = PosCrcLo;
                end
                PosCrcLo: begin
                    n_crc_lo = r_in_byte;
                    n_pos    = PosCrcHi;
                end
                PosCrcHi: begin
                    w_emit = 1'b1;
                    n_pos  = PosIdle;
                end
                PosIdle: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_mask  = r_out_mask;
        n_out_ok    = r_out_ok;
        if (w_adv) begin
            n_out_valid = w_emit;
        end
        if (w_emit) begin
            n_out_mask = w_ok ? r_mask : '0;
            n_out_ok   = w_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= PosIdle;
            r_crc       <= '0;
            r_mask      <= '0;
            r_crc_lo    <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_mask      <= n_mask;
            r_crc_lo    <= n_crc_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
        r_out_mask <= n_out_mask;
        r_out_ok   <= n_out_ok;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_mask;
    assign m_axis_tuser  = r_out_ok;

    // a failed check never shows a mask
    a_bad_crc_zero_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_mask == '0)
        else $error("mask not zero on bad crc");

    // a result leaves the frame idle
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_pos == PosIdle && r_out_valid)
        else $error("frame not closed after result");

    // idle bytes leave the state alone
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && !r_in_start && r_pos == PosIdle |=> $stable(r_crc) && $stable(r_mask)
            && r_pos == PosIdle)
        else $error("idle byte changed state");

    // input stalls only when both stages are full and the sink stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("spurious input stall");

endmodule
`default_nettype wire
